// ----- src/f12ct_pkg.sv -----
// Shared constants, codes and types of the FAT12 cluster table engine.
// No dependencies; compile first.
package f12ct_pkg;

   localparam int unsigned ENTRY_COUNT_INT = 4096;
   localparam int unsigned STORE_BYTES_INT = (ENTRY_COUNT_INT * 3 + 1) / 2;

   localparam int unsigned ADDR_W = 13;
   localparam int unsigned CLUS_W = 12;
   localparam int unsigned LIMIT_W = 13;

   localparam logic [ADDR_W-1:0]  STORE_BYTES  = ADDR_W'(STORE_BYTES_INT);
   localparam logic [ADDR_W-1:0]  ENTRY_COUNT  = ADDR_W'(ENTRY_COUNT_INT);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd2849;
   localparam logic [CLUS_W-1:0]  END_OF_CHAIN = 12'hFFF;
   localparam logic [CLUS_W-1:0]  STEP_MAX     = 12'hFFF;
   localparam logic [ADDR_W-1:0]  CHAIN_MIN    = 13'd2;
   localparam logic [ADDR_W-1:0]  CHAIN_END    = 13'hFF8;

   localparam logic [2:0] K_LOAD_BYTE   = 3'd0;
   localparam logic [2:0] K_READ_BYTE   = 3'd1;
   localparam logic [2:0] K_READ_ENTRY  = 3'd2;
   localparam logic [2:0] K_WRITE_ENTRY = 3'd3;
   localparam logic [2:0] K_ALLOCATE    = 3'd4;
   localparam logic [2:0] K_FREE_CHAIN  = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_BOUND    = 2'd2;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } store_req_type;

endpackage

// ----- src/f12ct_req_if.sv -----
// Request channel of the FAT12 cluster table engine: valid, ready, item fields.
// Depends on f12ct_pkg.
interface f12ct_req_if;
   import f12ct_pkg::*;

   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic [ADDR_W-1:0] byte_addr;
   logic [7:0]        byte_value;
   logic [CLUS_W-1:0] cluster;
   logic [CLUS_W-1:0] entry_value;

   modport source (output valid, kind, byte_addr, byte_value, cluster, entry_value,
                   input ready);
   modport sink   (input valid, kind, byte_addr, byte_value, cluster, entry_value,
                   output ready);
endinterface

// ----- src/f12ct_rsp_if.sv -----
// Response channel of the FAT12 cluster table engine: valid, ready, result fields.
// Depends on f12ct_pkg.
interface f12ct_rsp_if;
   import f12ct_pkg::*;

   logic              valid;
   logic              ready;
   logic [CLUS_W-1:0] data;
   logic [1:0]        status;
   logic [CLUS_W-1:0] freed_count;

   modport source (output valid, data, status, freed_count, input ready);
   modport sink   (input valid, data, status, freed_count, output ready);
endinterface

// ----- src/f12ct_store.sv -----
// Single-port byte store holding the packed FAT12 table, registered read data.
// Depends on f12ct_pkg.
module f12ct_store (
   input  logic                    clock,
   input  f12ct_pkg::store_req_type store_req,
   output logic [7:0]              rdata
);
   import f12ct_pkg::*;

   logic [7:0] mem [STORE_BYTES_INT];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (store_req.en) begin
         if (store_req.we) begin
            mem[store_req.addr] <= store_req.wdata;
         end else begin
            rdata_ff <= mem[store_req.addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/fat12_cluster_table_engine.sv -----
// Top level of the FAT12 cluster table engine: sequencer, limit register, result register.
// Depends on f12ct_pkg, f12ct_req_if, f12ct_rsp_if and f12ct_store.
//
//   channel  | dir | handshake          | beat
//   req_if   | in  | valid/ready        | kind, byte_addr, byte_value, cluster, entry_value
//   rsp_if   | out | valid/ready        | data, status, freed_count
//   csr      | in  | csr_we, csr_wdata  | cluster_limit
//
// Beats are taken one at a time.
// Allocate marks the first free entry from cluster 2 up; free chain clears its links.
// The single-port byte store serves one byte per cycle.
// Reset: synchronous, active high; limit returns to 2849; store contents undefined.
// A result waits in the output register while the next beat is taken.
module fat12_cluster_table_engine (
   input  logic                          clock,
   input  logic                          reset,
   f12ct_req_if.sink                     req_if,
   f12ct_rsp_if.source                   rsp_if,
   input  logic                          csr_we,
   input  logic [f12ct_pkg::LIMIT_W-1:0] csr_wdata
);
   import f12ct_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b00000000001,
      S_BYTE     = 11'b00000000010,
      S_BYTE_END = 11'b00000000100,
      S_CHECK    = 11'b00000001000,
      S_ADDR     = 11'b00000010000,
      S_RD_LO    = 11'b00000100000,
      S_RD_HI    = 11'b00001000000,
      S_EVAL     = 11'b00010000000,
      S_WR_HI    = 11'b00100000000,
      S_WR_LO    = 11'b01000000000,
      S_FINISH   = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         kind_ff, kind_in;
   logic [ADDR_W-1:0]  baddr_ff, baddr_in;
   logic [7:0]         bval_ff, bval_in;
   logic [ADDR_W-1:0]  cur_ff, cur_in;
   logic [CLUS_W-1:0]  ev_ff, ev_in;
   logic [ADDR_W-1:0]  off_ff, off_in;
   logic [7:0]         lo_ff, lo_in;
   logic [15:0]        word_ff, word_in;
   logic [CLUS_W-1:0]  count_ff, count_in;
   logic [CLUS_W-1:0]  res_data_ff, res_data_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [CLUS_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [CLUS_W-1:0]  rsp_freed_ff, rsp_freed_in;

   store_req_type      store_req;
   logic [7:0]         rdata;
   logic [15:0]        word_rd;
   logic [CLUS_W-1:0]  entry;
   logic [CLUS_W-1:0]  new_val;
   logic [LIMIT_W-1:0] top;
   logic [CLUS_W-1:0]  bound;
   logic               in_chain;
   logic               baddr_ok;
   logic               accept;
   logic               rsp_load;

   f12ct_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rdata     (rdata)
   );

   assign top      = (limit_ff < ENTRY_COUNT) ? limit_ff : ENTRY_COUNT;
   assign bound    = (top > LIMIT_W'(STEP_MAX)) ? STEP_MAX : top[CLUS_W-1:0];
   assign in_chain = (cur_ff >= CHAIN_MIN) && (cur_ff < CHAIN_END) && (cur_ff < ENTRY_COUNT);
   assign baddr_ok = baddr_ff < STORE_BYTES;
   assign word_rd  = {rdata, lo_ff};
   assign entry    = cur_ff[0] ? word_rd[15:4] : word_rd[11:0];

   always_comb begin
      unique case (kind_ff)
         K_ALLOCATE:   new_val = END_OF_CHAIN;
         K_FREE_CHAIN: new_val = '0;
         default:      new_val = ev_ff;
      endcase
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_load     = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      baddr_in      = baddr_ff;
      bval_in       = bval_ff;
      cur_in        = cur_ff;
      ev_in         = ev_ff;
      off_in        = off_ff;
      lo_in         = lo_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      store_req     = '{en: 1'b0, we: 1'b0, addr: off_ff, wdata: word_ff[7:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in       = req_if.kind;
               baddr_in      = req_if.byte_addr;
               bval_in       = req_if.byte_value;
               ev_in         = req_if.entry_value;
               cur_in        = (req_if.kind == K_ALLOCATE) ? CHAIN_MIN
                                                           : {1'b0, req_if.cluster};
               count_in      = '0;
               res_data_in   = '0;
               res_status_in = ST_OK;
               priority case (req_if.kind)
                  K_LOAD_BYTE, K_READ_BYTE: state_in = S_BYTE;
                  K_READ_ENTRY, K_WRITE_ENTRY:
                     state_in = ({1'b0, req_if.cluster} < ENTRY_COUNT) ? S_ADDR : S_FINISH;
                  K_ALLOCATE, K_FREE_CHAIN: state_in = S_CHECK;
                  default:                  state_in = S_FINISH;
               endcase
            end
         end
         S_BYTE: begin
            store_req = '{en: baddr_ok, we: (kind_ff == K_LOAD_BYTE), addr: baddr_ff,
                          wdata: bval_ff};
            state_in  = S_BYTE_END;
         end
         S_BYTE_END: begin
            if (kind_ff == K_READ_BYTE && baddr_ok) begin
               res_data_in = {4'b0, rdata};
            end
            state_in = S_FINISH;
         end
         S_CHECK: begin
            if (kind_ff == K_ALLOCATE) begin
               if (cur_ff >= top) begin
                  res_status_in = ST_NO_SPACE;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_ADDR;
               end
            end else if (!in_chain) begin
               state_in = S_FINISH;
            end else if (count_ff == bound) begin
               res_status_in = ST_BOUND;
               state_in      = S_FINISH;
            end else begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            off_in   = cur_ff + (cur_ff >> 1);
            state_in = S_RD_LO;
         end
         S_RD_LO: begin
            store_req = '{en: 1'b1, we: 1'b0, addr: off_ff, wdata: word_ff[7:0]};
            off_in    = off_ff + ADDR_W'(1);
            state_in  = S_RD_HI;
         end
         S_RD_HI: begin
            store_req = '{en: 1'b1, we: 1'b0, addr: off_ff, wdata: word_ff[7:0]};
            lo_in     = rdata;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            word_in = cur_ff[0] ? {new_val, word_rd[3:0]} : {word_rd[15:12], new_val};
            priority case (kind_ff)
               K_READ_ENTRY: begin
                  res_data_in = entry;
                  state_in    = S_FINISH;
               end
               K_ALLOCATE: begin
                  if (entry == '0) begin
                     res_data_in = cur_ff[CLUS_W-1:0];
                     state_in    = S_WR_HI;
                  end else begin
                     cur_in   = cur_ff + ADDR_W'(1);
                     state_in = S_CHECK;
                  end
               end
               K_FREE_CHAIN: begin
                  cur_in   = {1'b0, entry};
                  count_in = count_ff + CLUS_W'(1);
                  state_in = S_WR_HI;
               end
               default: state_in = S_WR_HI;
            endcase
         end
         S_WR_HI: begin
            store_req = '{en: 1'b1, we: 1'b1, addr: off_ff, wdata: word_ff[15:8]};
            off_in    = off_ff - ADDR_W'(1);
            state_in  = S_WR_LO;
         end
         S_WR_LO: begin
            store_req = '{en: 1'b1, we: 1'b1, addr: off_ff, wdata: word_ff[7:0]};
            state_in  = (kind_ff == K_FREE_CHAIN) ? S_CHECK : S_FINISH;
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      limit_in      = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in  = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in   = rsp_load ? res_data_ff : rsp_data_ff;
      rsp_status_in = rsp_load ? res_status_ff : rsp_status_ff;
      rsp_freed_in  = rsp_load ? ((kind_ff == K_FREE_CHAIN) ? count_ff : '0) : rsp_freed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      baddr_ff      <= baddr_in;
      bval_ff       <= bval_in;
      cur_ff        <= cur_in;
      ev_ff         <= ev_in;
      off_ff        <= off_in;
      lo_ff         <= lo_in;
      word_ff       <= word_in;
      count_ff      <= count_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.data        = rsp_data_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.freed_count = rsp_freed_ff;

   a_bound_only_on_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff == ST_BOUND) |-> (kind_ff == K_FREE_CHAIN))
      else $error("step bound status outside free chain");

   a_nospace_only_on_alloc: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff == ST_NO_SPACE) |-> (kind_ff == K_ALLOCATE))
      else $error("no-space status outside allocate");

   a_count_within_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && kind_ff == K_FREE_CHAIN) |-> (count_ff <= bound))
      else $error("freed count beyond step bound");

   a_alloc_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && kind_ff == K_ALLOCATE) |-> (cur_ff >= CHAIN_MIN))
      else $error("allocate scan below first data cluster");

   a_write_states_only: assert property (@(posedge clock) disable iff (reset)
      (store_req.en && store_req.we) |->
         (state_ff == S_BYTE || state_ff == S_WR_HI || state_ff == S_WR_LO))
      else $error("store written outside a write step");

   a_result_pairs_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR_HI) |-> ($past(state_ff, 1) == S_EVAL))
      else $error("entry written without its read");

endmodule

// ----- dv/fat12_cluster_table_engine_test.sv -----
// Self-checking bench for fat12_cluster_table_engine: loads the used part of the byte store,
// then runs table operations through an in-bench copy of the table and checks result beats.
// Depends on f12ct_pkg, f12ct_req_if, f12ct_rsp_if and the engine RTL.
module fat12_cluster_table_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import f12ct_pkg::*;

   localparam logic [2:0] K_SPARE_6 = 3'd6;
   localparam logic [2:0] K_SPARE_7 = 3'd7;
   localparam int unsigned IDLE_PCT = 21;
   localparam int unsigned QUIET_LIMIT = 200000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned MAX_LIVE = 6;
   localparam int unsigned LOADED_ENTRIES = 256;
   localparam int unsigned LOADED_BYTES = LOADED_ENTRIES * 3 / 2;
   localparam int unsigned TOP_BYTES = 16;

   typedef struct packed {
      logic [2:0]        kind;
      logic [ADDR_W-1:0] byte_addr;
      logic [7:0]        byte_value;
      logic [CLUS_W-1:0] cluster;
      logic [CLUS_W-1:0] entry_value;
   } table_cmd_type;

   typedef struct packed {
      logic [CLUS_W-1:0] data;
      logic [1:0]        status;
      logic [CLUS_W-1:0] freed_count;
   } table_answer_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_we;
   logic [LIMIT_W-1:0] csr_wdata;

   f12ct_req_if req_if();
   f12ct_rsp_if rsp_if();

   fat12_cluster_table_engine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   logic [7:0]        fat_copy [STORE_BYTES_INT];
   bit                fat_known [STORE_BYTES_INT];
   int unsigned       limit_copy;
   table_answer_type  awaited_answers [$];
   logic [CLUS_W-1:0] live_heads [$];
   int unsigned       table_beats = 0;
   int unsigned       mismatches = 0;
   int unsigned       results_seen = 0;
   int unsigned       quiet_cycles = 0;
   bit                steady = 1'b0;

   always #5 clock = ~clock;

   function automatic logic [7:0] fat_byte(int unsigned a);
      return (a < STORE_BYTES_INT) ? fat_copy[a] : 8'h00;
   endfunction

   function automatic logic [CLUS_W-1:0] fat_get_entry(int unsigned c);
      logic [15:0] word;
      if (c >= ENTRY_COUNT_INT) return '0;
      word = {fat_byte(c + c / 2 + 1), fat_byte(c + c / 2)};
      return c[0] ? word[15:4] : word[11:0];
   endfunction

   function automatic void fat_set_entry(int unsigned c, logic [CLUS_W-1:0] v);
      int unsigned off;
      logic [15:0] word;
      if (c >= ENTRY_COUNT_INT) return;
      off = c + c / 2;
      word = {fat_byte(off + 1), fat_byte(off)};
      word = c[0] ? {v, word[3:0]} : {word[15:12], v};
      if (off < STORE_BYTES_INT) fat_copy[off] = word[7:0];
      if (off + 1 < STORE_BYTES_INT) fat_copy[off + 1] = word[15:8];
   endfunction

   function automatic bit byte_known(int unsigned a);
      return (a >= STORE_BYTES_INT) || fat_known[a];
   endfunction

   function automatic bit entry_known(int unsigned c);
      if (c >= ENTRY_COUNT_INT) return 1'b1;
      return byte_known(c + c / 2) && byte_known(c + c / 2 + 1);
   endfunction

   // true when the command reads only bytes that have been loaded
   function automatic bit cmd_safe(table_cmd_type cmd);
      int unsigned top, c, steps;
      bit seen [int unsigned];
      top = (limit_copy < ENTRY_COUNT_INT) ? limit_copy : ENTRY_COUNT_INT;
      case (cmd.kind)
         K_READ_BYTE: return byte_known(cmd.byte_addr);
         K_READ_ENTRY, K_WRITE_ENTRY: return entry_known(cmd.cluster);
         K_ALLOCATE: begin
            for (c = CHAIN_MIN; c < top; c++) begin
               if (!entry_known(c)) return 1'b0;
               if (fat_get_entry(c) == '0) return 1'b1;
            end
            return 1'b1;
         end
         K_FREE_CHAIN: begin
            if (top > STEP_MAX) top = STEP_MAX;
            c = cmd.cluster;
            steps = 0;
            while (c >= CHAIN_MIN && c < CHAIN_END && c < ENTRY_COUNT_INT && steps < top
                   && !seen.exists(c)) begin
               if (!entry_known(c)) return 1'b0;
               seen[c] = 1'b1;
               c = fat_get_entry(c);
               steps++;
            end
            return 1'b1;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic table_answer_type fat_apply(table_cmd_type cmd);
      table_answer_type ans;
      int unsigned top, c, nxt, freed;
      ans = '0;
      freed = 0;
      top = (limit_copy < ENTRY_COUNT_INT) ? limit_copy : ENTRY_COUNT_INT;
      case (cmd.kind)
         K_LOAD_BYTE: begin
            if (cmd.byte_addr < STORE_BYTES_INT) begin
               fat_copy[cmd.byte_addr] = cmd.byte_value;
               fat_known[cmd.byte_addr] = 1'b1;
            end
         end
         K_READ_BYTE: ans.data = CLUS_W'(fat_byte(cmd.byte_addr));
         K_READ_ENTRY: ans.data = fat_get_entry(cmd.cluster);
         K_WRITE_ENTRY: fat_set_entry(cmd.cluster, cmd.entry_value);
         K_ALLOCATE: begin
            c = CHAIN_MIN;
            while (c < top && fat_get_entry(c) != '0) c++;
            if (c < top) begin
               fat_set_entry(c, END_OF_CHAIN);
               ans.data = CLUS_W'(c);
            end else begin
               ans.status = ST_NO_SPACE;
            end
         end
         K_FREE_CHAIN: begin
            if (top > STEP_MAX) top = STEP_MAX;
            c = cmd.cluster;
            while (c >= CHAIN_MIN && c < CHAIN_END && c < ENTRY_COUNT_INT
                   && ans.status == ST_OK) begin
               if (freed == top) begin
                  ans.status = ST_BOUND;
               end else begin
                  nxt = fat_get_entry(c);
                  fat_set_entry(c, '0);
                  freed++;
                  c = nxt;
               end
            end
            ans.freed_count = CLUS_W'(freed);
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic table_cmd_type make_cmd(logic [2:0] kind);
      table_cmd_type cmd;
      int unsigned roll;
      cmd.kind = kind;
      cmd.byte_addr = ($urandom_range(7) == 0) ? ADDR_W'($urandom)
                                               : ADDR_W'($urandom_range(LOADED_BYTES - 1));
      cmd.byte_value = 8'($urandom);
      cmd.cluster = ($urandom_range(7) == 0) ? CLUS_W'($urandom)
                                             : CLUS_W'($urandom_range(LOADED_ENTRIES - 1));
      roll = $urandom_range(7);
      if (roll == 0) cmd.entry_value = CLUS_W'($urandom);
      else if (roll == 1) cmd.entry_value = CLUS_W'($urandom_range(END_OF_CHAIN, CHAIN_END));
      else cmd.entry_value = CLUS_W'($urandom_range(LOADED_ENTRIES - 1));
      return cmd;
   endfunction

   function automatic table_cmd_type entry_cmd(logic [2:0] kind, logic [CLUS_W-1:0] clus,
                                               logic [CLUS_W-1:0] value);
      table_cmd_type cmd;
      cmd = make_cmd(kind);
      cmd.cluster = clus;
      cmd.entry_value = value;
      return cmd;
   endfunction

   function automatic table_cmd_type byte_cmd(logic [2:0] kind, logic [ADDR_W-1:0] addr,
                                              logic [7:0] value);
      table_cmd_type cmd;
      cmd = make_cmd(kind);
      cmd.byte_addr = addr;
      cmd.byte_value = value;
      return cmd;
   endfunction

   task automatic issue_cmd(input table_cmd_type cmd, output table_answer_type ans);
      // drop a beat that would read bytes never loaded
      if (!cmd_safe(cmd)) begin
         ans = '1;
         return;
      end
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= cmd.kind;
      req_if.byte_addr   <= cmd.byte_addr;
      req_if.byte_value  <= cmd.byte_value;
      req_if.cluster     <= cmd.cluster;
      req_if.entry_value <= cmd.entry_value;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      ans = fat_apply(cmd);
      awaited_answers.push_back(ans);
      if (!(cmd.kind == K_LOAD_BYTE && cmd.byte_addr >= STORE_BYTES_INT)) table_beats++;
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_limit(int unsigned value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= LIMIT_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      limit_copy = value;
   endtask

   task automatic free_oldest_head();
      table_answer_type ans;
      issue_cmd(entry_cmd(K_FREE_CHAIN, live_heads.pop_front(), CLUS_W'($urandom)), ans);
   endtask

   task automatic preload_table();
      table_cmd_type cmd;
      table_answer_type ans;
      for (int unsigned a = 0; a < STORE_BYTES_INT; a++) begin
         if (a >= LOADED_BYTES && a < STORE_BYTES_INT - TOP_BYTES) continue;
         cmd = make_cmd(K_LOAD_BYTE);
         cmd.byte_addr = ADDR_W'(a);
         if (a == 0) cmd.byte_value = 8'hF0;
         else if (a < 3) cmd.byte_value = 8'hFF;
         else if ($urandom_range(99) >= 8) cmd.byte_value = 8'h00;
         issue_cmd(cmd, ans);
      end
   endtask

   task automatic test_edge_cases();
      table_answer_type ans;
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd0, 12'h000), ans);
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd1, 12'hFFF), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd1, 12'hABC), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd0, 12'h543), ans);
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd0, 12'h000), ans);
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd1, 12'h000), ans);
      issue_cmd(byte_cmd(K_READ_BYTE, 13'd0, 8'h00), ans);
      issue_cmd(byte_cmd(K_READ_BYTE, 13'd1, 8'hFF), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd4095, 12'hFFF), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd4094, 12'h000), ans);
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd4095, 12'h000), ans);
      issue_cmd(byte_cmd(K_READ_BYTE, ADDR_W'(STORE_BYTES_INT - 1), 8'h00), ans);
      issue_cmd(byte_cmd(K_LOAD_BYTE, ADDR_W'(STORE_BYTES_INT), 8'hFF), ans);
      issue_cmd(byte_cmd(K_LOAD_BYTE, 13'h1FFF, 8'hAA), ans);
      issue_cmd(byte_cmd(K_READ_BYTE, ADDR_W'(STORE_BYTES_INT), 8'h00), ans);
      issue_cmd(byte_cmd(K_READ_BYTE, 13'h1FFF, 8'h00), ans);
      issue_cmd(make_cmd(K_ALLOCATE), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd0, 12'h000), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd1, 12'h000), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'hFF8, 12'h000), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'hFFF, 12'h000), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'hFF7, 12'hFFF), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'hFF7, 12'h000), ans);
      issue_cmd(make_cmd(K_SPARE_6), ans);
      issue_cmd(make_cmd(K_SPARE_7), ans);
   endtask

   task automatic test_step_bound();
      table_answer_type ans;
      set_limit(3);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd10, 12'd11), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd11, 12'd12), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd12, 12'd13), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd13, END_OF_CHAIN), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd10, 12'h000), ans);
      issue_cmd(entry_cmd(K_READ_ENTRY, 12'd13, 12'h000), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd13, 12'h000), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd20, 12'd21), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd21, 12'd22), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd22, END_OF_CHAIN), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd20, 12'h000), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd2, 12'h000), ans);
      issue_cmd(make_cmd(K_ALLOCATE), ans);
      issue_cmd(make_cmd(K_ALLOCATE), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd2, 12'h000), ans);
      issue_cmd(entry_cmd(K_WRITE_ENTRY, 12'd30, 12'd30), ans);
      issue_cmd(entry_cmd(K_FREE_CHAIN, 12'd30, 12'h000), ans);
   endtask

   task automatic test_churn(int unsigned beats);
      table_answer_type ans;
      table_cmd_type cmd;
      logic [CLUS_W-1:0] chain [$];
      int unsigned stop_at, roll, links;
      stop_at = table_beats + beats;
      while (table_beats < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 45) begin
            chain = {};
            links = $urandom_range(6, 1);
            repeat (links) begin
               issue_cmd(make_cmd(K_ALLOCATE), ans);
               if (ans.status == ST_OK) chain.push_back(ans.data);
            end
            for (int i = 0; i + 1 < chain.size(); i++)
               issue_cmd(entry_cmd(K_WRITE_ENTRY, chain[i], chain[i + 1]), ans);
            if ($urandom_range(1) == 1)
               foreach (chain[i])
                  issue_cmd(entry_cmd(K_READ_ENTRY, chain[i], CLUS_W'($urandom)), ans);
            if (chain.size() != 0) begin
               if ($urandom_range(1) == 1) begin
                  issue_cmd(entry_cmd(K_FREE_CHAIN, chain[0], CLUS_W'($urandom)), ans);
               end else begin
                  live_heads.push_back(chain[0]);
               end
            end
         end else if (roll < 55 && live_heads.size() != 0) begin
            free_oldest_head();
         end else if (roll < 63) begin
            issue_cmd(make_cmd(K_READ_ENTRY), ans);
         end else if (roll < 70) begin
            cmd = make_cmd(K_WRITE_ENTRY);
            if ($urandom_range(1) == 1) cmd.entry_value = '0;
            issue_cmd(cmd, ans);
         end else if (roll < 78) begin
            issue_cmd(make_cmd(K_READ_BYTE), ans);
         end else if (roll < 84) begin
            cmd = make_cmd(K_LOAD_BYTE);
            if ($urandom_range(1) == 1) cmd.byte_value = '0;
            issue_cmd(cmd, ans);
         end else if (roll < 92) begin
            issue_cmd(make_cmd(K_ALLOCATE), ans);
            if (ans.status == ST_OK) live_heads.push_back(ans.data);
         end else begin
            issue_cmd(make_cmd(K_FREE_CHAIN), ans);
         end
         while (live_heads.size() > MAX_LIVE) free_oldest_head();
      end
   endtask

   always @(posedge clock) begin : check_results
      table_answer_type want;
      bit stray;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            results_seen++;
            stray = (awaited_answers.size() == 0);
            want = stray ? table_answer_type'('0) : awaited_answers.pop_front();
            if (stray || rsp_if.data !== want.data || rsp_if.status !== want.status
                || rsp_if.freed_count !== want.freed_count) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("beat %0d%s: expected data %h status %0d freed %0d, got %h %0d %0d",
                           results_seen, stray ? " (none outstanding)" : "", want.data,
                           want.status, want.freed_count, rsp_if.data, rsp_if.status,
                           rsp_if.freed_count);
            end
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= LIMIT_RESET;
      req_if.valid       <= 1'b0;
      req_if.kind        <= K_LOAD_BYTE;
      req_if.byte_addr   <= '0;
      req_if.byte_value  <= '0;
      req_if.cluster     <= '0;
      req_if.entry_value <= '0;
      limit_copy = LIMIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      preload_table();
      test_edge_cases();
      test_step_bound();
      set_limit(ENTRY_COUNT_INT);
      test_churn(300);
      set_limit(LIMIT_RESET);
      steady = 1'b1;
      test_churn(300);
      settle();
      steady = 1'b0;
      set_limit($urandom_range(300, 16));
      test_churn(200);
      set_limit($urandom_range(8, 3));
      test_churn(200);
      set_limit($urandom_range(ENTRY_COUNT_INT, 3));
      test_churn(250);
      settle();
      if (mismatches == 0 && awaited_answers.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
